### design/srec_pkg.sv
// Package for the S-record line checker.
// Holds shared constants, codes, transaction payload types and decode functions.
// Depends on nothing.
package srec_pkg;

   localparam int MAX_LINE_CHARS = 1024;
   localparam int MIN_LINE_EXTRA = 4;
   localparam int POS_W          = $clog2(MAX_LINE_CHARS + 1);
   localparam int BIDX_W         = POS_W - 1;

   localparam logic [7:0]  CHAR_S    = 8'h53;
   localparam logic [7:0]  CHAR_CR   = 8'h0D;
   localparam logic [7:0]  CHAR_LF   = 8'h0A;
   localparam logic [23:0] GOOD_MAX  = 24'hFFFFFF;

   localparam logic [3:0] REC_S0 = 4'd0;
   localparam logic [3:0] REC_S1 = 4'd1;
   localparam logic [3:0] REC_S2 = 4'd2;
   localparam logic [3:0] REC_S3 = 4'd3;
   localparam logic [3:0] REC_S4 = 4'd4;
   localparam logic [3:0] REC_S5 = 4'd5;
   localparam logic [3:0] REC_S6 = 4'd6;
   localparam logic [3:0] REC_S7 = 4'd7;
   localparam logic [3:0] REC_S8 = 4'd8;
   localparam logic [3:0] REC_S9 = 4'd9;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_NO_S       = 4'd1,
      ST_NON_HEX    = 4'd2,
      ST_FIRST_NOT0 = 4'd3,
      ST_BAD_TYPE   = 4'd4,
      ST_SHORT      = 4'd5,
      ST_END_COUNT  = 4'd6,
      ST_ADDR_MISM  = 4'd7,
      ST_CHECKSUM   = 4'd8
   } status_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       file_start;
   } req_payload_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [3:0]  status;
      logic [3:0]  rec_type;
      logic [31:0] address;
      logic [7:0]  payload_len;
   } rsp_payload_type;

   // Bit 4 set means the character is not a hex digit.
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b0, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b0, 4'(c - 8'h57)};
      end else begin
         r = 5'b10000;
      end
      return r;
   endfunction

   function automatic logic type_valid(input logic [3:0] t);
      return (t <= REC_S9) && (t != REC_S4);
   endfunction

   function automatic logic [2:0] addr_bytes(input logic [3:0] t);
      logic [2:0] r;
      case (t)
         REC_S2, REC_S6, REC_S8: r = 3'd3;
         REC_S3, REC_S7:         r = 3'd4;
         default:                r = 3'd2;
      endcase
      return r;
   endfunction

endpackage

### design/srec_if.sv
// Channel interfaces for the S-record line checker: character input and results.
// Depends on nothing.
interface srec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       file_start;

   modport source (output valid, output ch, output file_start, input ready);
   modport sink   (input valid, input ch, input file_start, output ready);
endinterface

interface srec_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_byte;
   logic [7:0]  byte_index;
   logic [3:0]  status;
   logic [3:0]  rec_type;
   logic [31:0] address;
   logic [7:0]  payload_len;

   modport source (output valid, output kind, output data_byte, output byte_index,
                   output status, output rec_type, output address, output payload_len,
                   input ready);
   modport sink   (input valid, input kind, input data_byte, input byte_index,
                   input status, input rec_type, input address, input payload_len,
                   output ready);
endinterface

### design/srecord_line_checker.sv
// S-record line checker: takes Motorola S-record text one character per transaction
// and returns data bytes of S1/S2/S3 records as they decode, plus one status at each
// line end. One character is accepted every clock cycle when the result side keeps
// up. The combinational line-state update works on the input register and loads the
// result register, so a character passes the input register and then the result
// register before its result is offered. Data bytes are tentative: the status of the
// same line may still report an error. A character with file_start set clears the
// line and record counts first. Empty lines produce nothing. Depends on srec_pkg,
// srec_if and the stages.
module srecord_line_checker (
   input  logic       clock,
   input  logic       reset,
   srec_req_if.sink   req_chan,
   srec_rsp_if.source rsp_chan
);
   import srec_pkg::*;

   logic            in_valid;
   req_payload_type in_data;
   logic            space;
   logic            advance;
   logic            res_valid;
   rsp_payload_type res_data;

   assign advance = in_valid && space;

   srec_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .in_valid (in_valid),
      .in_data  (in_data)
   );

   srec_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_data   (in_data),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   srec_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && res_valid),
      .res_data (res_data),
      .space    (space),
      .rsp_chan (rsp_chan)
   );

endmodule

### design/srec_in_stage.sv
// Input register of the S-record line checker.
// Captures one character transaction and holds it until the parser consumes it.
// Depends on srec_pkg and srec_if.
module srec_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   srec_req_if.sink                  req_chan,
   input  logic                      advance,
   output logic                      in_valid,
   output srec_pkg::req_payload_type in_data
);
   import srec_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type data_ff;

   assign req_chan.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         data_ff.ch         <= req_chan.ch;
         data_ff.file_start <= req_chan.file_start;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule

### design/srec_parser.sv
// Line state and combinational decode of the S-record line checker.
// Updates the line state for one character and forms at most one result.
// Depends on srec_pkg.
module srec_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  srec_pkg::req_payload_type in_data,
   output logic                      res_valid,
   output srec_pkg::rsp_payload_type res_data
);
   import srec_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       type_ff, type_in;
   logic [7:0]       count_ff, count_in;
   logic [31:0]      addr_ff, addr_in;
   logic [7:0]       sum_ff, sum_in;
   logic [3:0]       high_ff, high_in;
   logic [7:0]       got_ff, got_in;
   status_type       err_ff, err_in;
   logic             pend_ff, pend_in;
   logic [23:0]      good_ff, good_in;

   always_comb begin
      logic [POS_W-1:0]  pos_c;
      logic [3:0]        type_c;
      logic [7:0]        count_c;
      logic [31:0]       addr_c;
      logic [7:0]        sum_c;
      logic [3:0]        high_c;
      logic [7:0]        got_c;
      status_type        err_c;
      logic [2:0]        ab;
      logic [4:0]        nib;
      logic [7:0]        byte_v;
      logic [BIDX_W-1:0] bidx;
      logic [BIDX_W-1:0] didx;
      logic [POS_W-1:0]  min_len;
      status_type        st;
      logic [7:0]        len;
      logic              clr;

      clr     = in_data.file_start;
      pos_c   = clr ? '0 : pos_ff;
      type_c  = clr ? REC_S0 : type_ff;
      count_c = clr ? '0 : count_ff;
      addr_c  = clr ? '0 : addr_ff;
      sum_c   = clr ? '0 : sum_ff;
      high_c  = clr ? '0 : high_ff;
      got_c   = clr ? '0 : got_ff;
      err_c   = clr ? ST_OK : err_ff;
      pend_in = clr ? 1'b1 : pend_ff;
      good_in = clr ? '0 : good_ff;

      pos_in   = pos_c;
      type_in  = type_c;
      count_in = count_c;
      addr_in  = addr_c;
      sum_in   = sum_c;
      high_in  = high_c;
      got_in   = got_c;
      err_in   = err_c;

      ab      = addr_bytes(type_c);
      nib     = nibble_of(in_data.ch);
      byte_v  = {high_c, nib[3:0]};
      bidx    = pos_c[POS_W-1:1] - BIDX_W'(1);
      didx    = bidx - BIDX_W'(ab) - BIDX_W'(1);
      min_len = POS_W'({count_c, 1'b0}) + POS_W'(MIN_LINE_EXTRA);
      len     = '0;
      st      = ST_OK;

      res_valid            = 1'b0;
      res_data.kind        = KIND_DATA;
      res_data.data_byte   = '0;
      res_data.byte_index  = '0;
      res_data.status      = ST_OK;
      res_data.rec_type    = type_c;
      res_data.address     = (type_c == REC_S0) ? '0 : addr_c;
      res_data.payload_len = '0;

      if (in_data.ch == CHAR_CR || in_data.ch == CHAR_LF) begin
         if (pos_c != '0) begin
            if (err_c != ST_OK) begin
               st = err_c;
            end else if (pos_c < POS_W'(2)) begin
               st = pend_in ? ST_FIRST_NOT0 : ST_BAD_TYPE;
            end else if (pend_in && type_c != REC_S0) begin
               st = ST_FIRST_NOT0;
            end else if (!type_valid(type_c)) begin
               st = ST_BAD_TYPE;
            end else if (pos_c < min_len) begin
               st = ST_SHORT;
            end else if (count_c < 8'(ab) + 8'd1) begin
               st = ST_SHORT;
            end else if ((type_c == REC_S7 && count_c != 8'd5) ||
                         (type_c == REC_S8 && count_c != 8'd4) ||
                         (type_c == REC_S9 && count_c != 8'd3)) begin
               st = ST_END_COUNT;
            end else if ((type_c == REC_S5 || type_c == REC_S6) &&
                         addr_c != {8'd0, good_in}) begin
               st = ST_ADDR_MISM;
            end else if (~sum_c != got_c) begin
               st = ST_CHECKSUM;
            end
            if (pos_c >= POS_W'(2) && type_valid(type_c) && count_c >= 8'(ab) + 8'd1) begin
               len = count_c - 8'(ab) - 8'd1;
            end
            res_valid            = 1'b1;
            res_data.kind        = KIND_STATUS;
            res_data.status      = st;
            res_data.payload_len = len;
            if (st == ST_OK && type_c >= REC_S1 && type_c <= REC_S3 &&
                good_in != GOOD_MAX) begin
               good_in = good_in + 24'd1;
            end
            pend_in  = 1'b0;
            pos_in   = '0;
            type_in  = REC_S0;
            count_in = '0;
            addr_in  = '0;
            sum_in   = '0;
            high_in  = '0;
            got_in   = '0;
            err_in   = ST_OK;
         end
      end else begin
         if (pos_c < POS_W'(MAX_LINE_CHARS)) begin
            pos_in = pos_c + POS_W'(1);
         end
         if (err_c == ST_OK) begin
            if (pos_c == '0) begin
               if (in_data.ch != CHAR_S) begin
                  err_in = ST_NO_S;
               end
            end else if (nib[4]) begin
               err_in = ST_NON_HEX;
            end else if (pos_c == POS_W'(1)) begin
               type_in = nib[3:0];
            end else if (!pos_c[0]) begin
               high_in = nib[3:0];
            end else if (bidx == '0) begin
               count_in = byte_v;
               sum_in   = byte_v;
            end else if (bidx < BIDX_W'(count_c)) begin
               sum_in = sum_c + byte_v;
               if (bidx <= BIDX_W'(ab)) begin
                  addr_in = {addr_c[23:0], byte_v};
               end else if (type_c >= REC_S1 && type_c <= REC_S3) begin
                  res_valid            = 1'b1;
                  res_data.data_byte   = byte_v;
                  res_data.byte_index  = didx[7:0];
                  res_data.payload_len = count_c - 8'(ab) - 8'd1;
               end
            end else if (bidx == BIDX_W'(count_c)) begin
               got_in = byte_v;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         type_ff  <= REC_S0;
         count_ff <= '0;
         addr_ff  <= '0;
         sum_ff   <= '0;
         high_ff  <= '0;
         got_ff   <= '0;
         err_ff   <= ST_OK;
         pend_ff  <= 1'b1;
         good_ff  <= '0;
      end else if (advance) begin
         pos_ff   <= pos_in;
         type_ff  <= type_in;
         count_ff <= count_in;
         addr_ff  <= addr_in;
         sum_ff   <= sum_in;
         high_ff  <= high_in;
         got_ff   <= got_in;
         err_ff   <= err_in;
         pend_ff  <= pend_in;
         good_ff  <= good_in;
      end
   end

endmodule

### design/srec_out_stage.sv
// Result register of the S-record line checker.
// Holds one result transaction until the consumer takes it.
// Depends on srec_pkg and srec_if.
module srec_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  srec_pkg::rsp_payload_type res_data,
   output logic                      space,
   srec_rsp_if.source                rsp_chan
);
   import srec_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type data_ff;

   assign space = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res_data;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.kind        = data_ff.kind;
   assign rsp_chan.data_byte   = data_ff.data_byte;
   assign rsp_chan.byte_index  = data_ff.byte_index;
   assign rsp_chan.status      = data_ff.status;
   assign rsp_chan.rec_type    = data_ff.rec_type;
   assign rsp_chan.address     = data_ff.address;
   assign rsp_chan.payload_len = data_ff.payload_len;

endmodule

### design/srec_checker.sv
// Port-level checks of the S-record line checker, bound to its top level.
// Depends on srec_pkg.
module srec_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [7:0]  rsp_byte_index,
   input logic [3:0]  rsp_status,
   input logic [3:0]  rsp_rec_type,
   input logic [7:0]  rsp_payload_len
);
   import srec_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_data_byte))
      else $error("Stalled result transaction changed.");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS |->
      rsp_data_byte == 8'd0 && rsp_byte_index == 8'd0 && rsp_status <= ST_CHECKSUM)
      else $error("Status transaction carries data fields.");

   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DATA |->
      rsp_status == ST_OK && rsp_rec_type >= REC_S1 && rsp_rec_type <= REC_S3 &&
      rsp_byte_index < rsp_payload_len)
      else $error("Data transaction out of its record.");

endmodule

bind srecord_line_checker srec_checker u_srec_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.kind),
   .rsp_data_byte   (rsp_chan.data_byte),
   .rsp_byte_index  (rsp_chan.byte_index),
   .rsp_status      (rsp_chan.status),
   .rsp_rec_type    (rsp_chan.rec_type),
   .rsp_payload_len (rsp_chan.payload_len)
);
